/* hdl/sdd_pkg.sv */
`timescale 1ns / 1ps

package sdd_pkg;

  // Command codes carried on the command field.
  typedef enum logic [1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_NUMBER    = 2'd1,
    CMD_DOT_UNITS = 2'd2,
    CMD_DOT_TENS  = 2'd3
  } command_t;

  // Control shared by every cell of the shift chain.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  localparam int unsigned FrameBits = 16;
  localparam logic [7:0] DotMask = 8'h10;
  localparam logic [6:0] MaxValue = 7'd99;

  // Segment font for decimal digits; no glyph uses the dot bit.
  function automatic logic [7:0] seg_font(input logic [3:0] digit);
    logic [7:0] pattern;
    unique case (digit)
      4'd0: pattern = 8'hEE;
      4'd1: pattern = 8'h28;
      4'd2: pattern = 8'hCD;
      4'd3: pattern = 8'h6D;
      4'd4: pattern = 8'h2B;
      4'd5: pattern = 8'h67;
      4'd6: pattern = 8'hE7;
      4'd7: pattern = 8'h2C;
      4'd8: pattern = 8'hEF;
      4'd9: pattern = 8'h6F;
      default: pattern = 8'h00;
    endcase
    return pattern;
  endfunction

endpackage

/* hdl/sdd_cell.sv */
`timescale 1ns / 1ps

module sdd_cell (
  input  logic               clk,
  input  sdd_pkg::cell_ctrl_t ctrl,
  input  logic               load_bit,
  input  logic               shift_in,
  output logic               q
);
  import sdd_pkg::*;

  // One bit of the frame: parallel load from the segment registers, or
  // take the neighbor's bit as the frame moves toward the output.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= load_bit;
    end else if (ctrl.shift) begin
      q <= shift_in;
    end
  end

endmodule

/* hdl/two_digit_seven_segment_shift_driver_unit.sv */
`timescale 1ns / 1ps
// An accepted request is held as pending and then loaded into the shift chain, which offers its first bit.
// The 16-cell shift chain sends one bit per cycle while out_ready is high.
// A new request is accepted while the previous frame is still shifting out.
// Reset (synchronous, active high) clears both segment patterns, the
// blank_leading_zero register and all valid flags.

module two_digit_seven_segment_shift_driver_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [6:0] value,
  input  logic       dot_on,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       serial_bit,
  output logic [3:0] bit_index,
  output logic       last
);
  import sdd_pkg::*;

  logic [7:0]  units_segments;
  logic [7:0]  tens_segments;
  logic        blank_leading_zero;
  logic        pend_valid;
  logic [7:0]  units_next;
  logic [7:0]  tens_next;
  logic [6:0]  value_clamped;
  logic [14:0] tens_product;
  logic [3:0]  tens_digit;
  logic [6:0]  tens_x10;
  logic [3:0]  ones_digit;
  logic [FrameBits-1:0] frame;
  logic [FrameBits-1:0] chain;
  logic        in_fire;
  logic        out_fire;
  logic        frame_done;
  logic        load;
  cell_ctrl_t  ctrl;

  assign cfg_ready = 1'b1;

  // Split the clamped value into digits: tens by reciprocal multiply.
  assign value_clamped = (value > MaxValue) ? MaxValue : value;
  assign tens_product  = 15'(value_clamped) * 15'd205;
  assign tens_digit    = tens_product[14:11];
  assign tens_x10      = 7'({3'b000, tens_digit} << 3) + 7'({3'b000, tens_digit} << 1);
  assign ones_digit    = 4'(value_clamped - tens_x10);

  // Next segment patterns for the incoming request.
  always_comb begin
    units_next = units_segments;
    tens_next  = tens_segments;
    unique case (command_t'(command))
      CMD_CLEAR: begin
        units_next = units_segments & DotMask;
        tens_next  = tens_segments & DotMask;
      end
      CMD_NUMBER: begin
        units_next = seg_font(ones_digit) | (units_segments & DotMask);
        if (blank_leading_zero && (tens_digit == 4'd0)) begin
          tens_next = tens_segments & DotMask;
        end else begin
          tens_next = seg_font(tens_digit) | (tens_segments & DotMask);
        end
      end
      CMD_DOT_UNITS: begin
        units_next = dot_on ? (units_segments | DotMask) : (units_segments & ~DotMask);
      end
      CMD_DOT_TENS: begin
        tens_next = dot_on ? (tens_segments | DotMask) : (tens_segments & ~DotMask);
      end
      default: begin
        units_next = units_segments;
      end
    endcase
  end

  // Handshake control. The pending frame is always the current segment
  // registers, so only a flag is kept for it.
  assign out_fire   = out_valid && out_ready;
  assign frame_done = out_fire && (bit_index == 4'(FrameBits - 1));
  assign load       = pend_valid && (!out_valid || frame_done);
  assign in_ready   = !pend_valid || load;
  assign in_fire    = in_valid && in_ready;
  assign ctrl       = '{load: load, shift: out_fire};

  always_ff @(posedge clk) begin
    if (rst) begin
      units_segments     <= 8'h00;
      tens_segments      <= 8'h00;
      blank_leading_zero <= 1'b0;
      pend_valid         <= 1'b0;
      out_valid          <= 1'b0;
      bit_index          <= 4'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        blank_leading_zero <= cfg_data;
      end
      if (in_fire) begin
        units_segments <= units_next;
        tens_segments  <= tens_next;
      end
      pend_valid <= in_fire || (pend_valid && !load);
      if (load) begin
        out_valid <= 1'b1;
        bit_index <= 4'd0;
      end else if (frame_done) begin
        out_valid <= 1'b0;
        bit_index <= 4'd0;
      end else if (out_fire) begin
        bit_index <= bit_index + 4'd1;
      end
    end
  end

  // Shift chain: the top cell holds the bit on the output.
  assign frame = {units_segments, tens_segments};

  for (genvar i = 0; i < FrameBits; i++) begin : g_cell
    logic shift_in;
    if (i == 0) begin : g_first
      assign shift_in = 1'b0;
    end else begin : g_rest
      assign shift_in = chain[i-1];
    end
    sdd_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_bit (frame[i]),
      .shift_in (shift_in),
      .q        (chain[i])
    );
  end

  assign serial_bit = chain[FrameBits-1];
  assign last       = out_valid && (bit_index == 4'(FrameBits - 1));

  // A waiting frame enters the idle chain at the next edge.
  a_pend_loads: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !out_valid |=> out_valid && (bit_index == 4'd0))
    else $error("pending frame did not enter idle chain");

  // Bits of a frame are delivered in order without skips.
  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (bit_index != 4'd15)
      |=> out_valid && (bit_index == $past(bit_index) + 4'd1))
    else $error("bit index did not advance by one");

  // Input is held off only while a frame waits for the chain.
  a_ready_pend: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> pend_valid && out_valid)
    else $error("input stalled without a waiting frame");

  // Reset leaves no frame in flight.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !pend_valid)
    else $error("frame in flight after reset");

endmodule

/* sim/two_digit_seven_segment_shift_driver_unit_tb.sv */
`timescale 1ns / 1ps

module two_digit_seven_segment_shift_driver_unit_tb;
  import sdd_pkg::*;

  localparam int StallLimit = 4000;
  localparam int HoldOffCycles = 200;
  localparam int ItemsPerPhase = 28;
  localparam int MaxReported = 10;
  localparam logic [7:0] SegDot = 8'h10;
  // Glyphs for digits 0..9, digit 0 in the low byte.
  localparam logic [79:0] DigitGlyphs = {
    8'h6F, 8'hEF, 8'h2C, 8'hE7, 8'h67, 8'h2B, 8'h6D, 8'hCD, 8'h28, 8'hEE
  };

  // One serial bit of a frame as the block should present it.
  typedef struct packed {
    logic       data;
    logic [3:0] position;
    logic       frame_end;
  } frame_bit_t;

  // One row of the directed table; a typed row carries its own expected patterns.
  typedef struct packed {
    command_t   cmd;
    logic [6:0] num;
    logic       dot;
    logic       blank_zero;
    logic       typed;
    logic [7:0] units;
    logic [7:0] tens;
  } table_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  command_t   command = CMD_CLEAR;
  logic [6:0] value = 7'd0;
  logic       dot_on = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       serial_bit;
  logic [3:0] bit_index;
  logic       last;

  // Shadow of the display state and of the leading-zero register.
  logic [7:0] shown_units = 8'h00;
  logic [7:0] shown_tens = 8'h00;
  logic       blank_zero_mode = 1'b0;

  frame_bit_t pending_bits[$];
  table_row_t steps[$];
  int         error_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         hold_off_req = 1'b0;
  int         stall_count = 0;

  two_digit_seven_segment_shift_driver_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .value     (value),
    .dot_on    (dot_on),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .serial_bit(serial_bit),
    .bit_index (bit_index),
    .last      (last)
  );

  always #2 clk = ~clk;

  // Applies one request to the shadow patterns and returns {units, tens}.
  function automatic logic [15:0] apply_display_command(input command_t cmd,
                                                        input logic [6:0] num,
                                                        input logic dot);
    int         shown;
    logic [3:0] ones_digit;
    logic [3:0] tens_digit;
    shown = (num > 7'd99) ? 99 : int'(num);
    ones_digit = 4'(shown % 10);
    tens_digit = 4'(shown / 10);
    case (cmd)
      CMD_CLEAR: begin
        shown_units = shown_units & SegDot;
        shown_tens = shown_tens & SegDot;
      end
      CMD_NUMBER: begin
        shown_units = DigitGlyphs[8 * ones_digit +: 8] | (shown_units & SegDot);
        if (blank_zero_mode && tens_digit == 4'd0) begin
          shown_tens = shown_tens & SegDot;
        end else begin
          shown_tens = DigitGlyphs[8 * tens_digit +: 8] | (shown_tens & SegDot);
        end
      end
      CMD_DOT_UNITS: begin
        shown_units = dot ? (shown_units | SegDot) : (shown_units & ~SegDot);
      end
      default: begin
        shown_tens = dot ? (shown_tens | SegDot) : (shown_tens & ~SegDot);
      end
    endcase
    return {shown_units, shown_tens};
  endfunction

  // Queues the 16 bits of a frame: units byte first, each byte MSB first.
  task automatic queue_frame(input logic [7:0] units, input logic [7:0] tens);
    frame_bit_t fb;
    logic [7:0] byte_val;
    for (int k = 0; k < 16; k++) begin
      byte_val = (k < 8) ? units : tens;
      fb.data = byte_val[7 - (k % 8)];
      fb.position = 4'(k);
      fb.frame_end = (k == 15);
      pending_bits.push_back(fb);
    end
  endtask

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MaxReported) begin
      $display("%s", msg);
    end
  endtask

  // Offers one request after an optional random gap and predicts its frame.
  task automatic send_request(input command_t cmd, input logic [6:0] num, input logic dot,
                              input logic typed, input logic [7:0] units,
                              input logic [7:0] tens);
    logic [15:0] patterns;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    value <= num;
    dot_on <= dot;
    do @(posedge clk); while (!in_ready);
    patterns = apply_display_command(cmd, num, dot);
    if (typed) begin
      queue_frame(units, tens);
    end else begin
      queue_frame(patterns[15:8], patterns[7:0]);
    end
  endtask

  task automatic send_random_request();
    logic [6:0] num;
    num = ($urandom_range(99) < 15) ? 7'($urandom_range(127, 100)) : 7'($urandom_range(99));
    send_request(command_t'($urandom_range(3)), num, 1'($urandom_range(1)), 1'b0,
                 8'h00, 8'h00);
  endtask

  // Stops offering and waits until every predicted bit has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_bits.size() != 0);
  endtask

  // Writes the leading-zero register once the block is idle.
  task automatic write_blank_zero(input logic setting);
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= setting;
    do @(posedge clk); while (!cfg_ready);
    blank_zero_mode = setting;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random ready, with a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted bit with the oldest prediction.
  always @(posedge clk) begin
    frame_bit_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_bits.size() == 0) begin
        note_error($sformatf("unexpected bit: data %0b index %0d last %0b",
                             serial_bit, bit_index, last));
      end else begin
        want = pending_bits.pop_front();
        if (serial_bit !== want.data) begin
          note_error($sformatf("serial_bit at index %0d: expected %0b, got %0b",
                               want.position, want.data, serial_bit));
        end
        if (bit_index !== want.position) begin
          note_error($sformatf("bit_index: expected %0d, got %0d",
                               want.position, bit_index));
        end
        if (last !== want.frame_end) begin
          note_error($sformatf("last at index %0d: expected %0b, got %0b",
                               want.position, want.frame_end, last));
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= StallLimit) begin
      $display("two_digit_seven_segment_shift_driver_unit_tb: errors");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    table_row_t row;

    // Directed rows; the first few start from the known reset state.
    steps.push_back('{CMD_CLEAR, 7'd0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00});
    steps.push_back('{CMD_NUMBER, 7'd0, 1'b0, 1'b0, 1'b1, 8'hEE, 8'hEE});
    steps.push_back('{CMD_NUMBER, 7'd99, 1'b0, 1'b0, 1'b1, 8'h6F, 8'h6F});
    steps.push_back('{CMD_NUMBER, 7'd127, 1'b0, 1'b0, 1'b1, 8'h6F, 8'h6F});
    steps.push_back('{CMD_NUMBER, 7'd100, 1'b0, 1'b0, 1'b1, 8'h6F, 8'h6F});
    steps.push_back('{CMD_DOT_UNITS, 7'd127, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_DOT_TENS, 7'd85, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_NUMBER, 7'd42, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_CLEAR, 7'd127, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_DOT_UNITS, 7'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_DOT_TENS, 7'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_NUMBER, 7'd5, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_NUMBER, 7'd18, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_NUMBER, 7'd23, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_NUMBER, 7'd36, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_NUMBER, 7'd47, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_NUMBER, 7'd59, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_NUMBER, 7'd60, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_NUMBER, 7'd71, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_NUMBER, 7'd84, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00});
    // Leading-zero blanking, with and without the tens dot lit.
    steps.push_back('{CMD_NUMBER, 7'd7, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_DOT_TENS, 7'd0, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_NUMBER, 7'd0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_NUMBER, 7'd10, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00});
    steps.push_back('{CMD_NUMBER, 7'd127, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, no idling on either side.
    foreach (steps[i]) begin
      row = steps[i];
      if (row.blank_zero != blank_zero_mode) begin
        write_blank_zero(row.blank_zero);
      end
      send_request(row.cmd, row.num, row.dot, row.typed, row.units, row.tens);
    end

    // Random part: receiver idles most, then sender idles most, then no idling.
    for (int phase = 0; phase < 3; phase++) begin
      write_blank_zero(phase % 2 == 1);
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 76 : 0;
      recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 32 : 0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (phase == 1 && n == ItemsPerPhase / 2) begin
          wait_drained();
        end
        // Long receiver hold-off while requests keep coming.
        if (phase == 2 && n == 4) begin
          hold_off_req = 1'b1;
        end
        send_random_request();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_bits.size() == 0) begin
      $display("two_digit_seven_segment_shift_driver_unit_tb: clean");
    end else begin
      $display("two_digit_seven_segment_shift_driver_unit_tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/sdd_pkg.sv
hdl/sdd_cell.sv
hdl/two_digit_seven_segment_shift_driver_unit.sv
sim/two_digit_seven_segment_shift_driver_unit_tb.sv
